FILE: src/hsv_to_rgb_converter_top_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property forms for the concurrent checks of the converter.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HSVC_ASSERT_SAME(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HSVC_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: src/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field types, sector codes and the exact divide-by-255 helper.
// ----------------------------------------------------------------------------
package hsvc_pkg;

  localparam int HUE_W   = 16;
  localparam int LEVEL_W = 8;
  localparam int SECT_W  = 3;

  typedef logic [HUE_W-1:0]   hue_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SECT_W-1:0]  sector_t;
  typedef logic [2*LEVEL_W-1:0] prod_t;

  localparam level_t LEVEL_MAX = 8'd255;

  localparam sector_t SECTOR_0 = 3'd0;
  localparam sector_t SECTOR_1 = 3'd1;
  localparam sector_t SECTOR_2 = 3'd2;
  localparam sector_t SECTOR_3 = 3'd3;
  localparam sector_t SECTOR_4 = 3'd4;
  localparam sector_t SECTOR_5 = 3'd5;

  typedef struct packed {
    hue_t   hue;
    level_t saturation;
    level_t brightness;
  } pixel_t;

  typedef struct packed {
    sector_t sector;
    level_t  fp;
    level_t  fq;
    level_t  ft;
    level_t  brightness;
  } factor_t;

  typedef struct packed {
    sector_t sector;
    level_t  p;
    level_t  q;
    level_t  t;
    level_t  brightness;
  } level_set_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } rgb_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic level_t div255(input prod_t x);
    logic [2*LEVEL_W:0] sum;
    sum = {1'b0, x} + {{(LEVEL_W+1){1'b0}}, x[2*LEVEL_W-1:LEVEL_W]} + 17'd1;
    return sum[2*LEVEL_W-1:LEVEL_W];
  endfunction

endpackage

FILE: src/hsvc_pix_if.sv
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid/ready channel carrying one HSV pixel per item.
// ----------------------------------------------------------------------------
interface hsvc_pix_if;
  logic             valid;
  logic             ready;
  hsvc_pkg::hue_t   hue;
  hsvc_pkg::level_t saturation;
  hsvc_pkg::level_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

FILE: src/hsvc_rgb_if.sv
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel carrying one RGB pixel per item.
// ----------------------------------------------------------------------------
interface hsvc_rgb_if;
  logic             valid;
  logic             ready;
  hsvc_pkg::level_t red;
  hsvc_pkg::level_t green;
  hsvc_pkg::level_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: src/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five register stages lie between the accepting edge and the first edge
// that can take the result.
// Throughput: one pixel per cycle while rgb.ready holds; each stage loads when empty or drained.
// Stalls back up stage by stage; bubbles are squeezed out.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv_to_rgb_converter_top (
  input  logic clk,
  input  logic rst,
  hsvc_pix_if.sink   pix,
  hsvc_rgb_if.source rgb
);
  import hsvc_pkg::*;

  pixel_t     pix_data;
  logic       fac_valid;
  logic       fac_ready;
  factor_t    fac_data;
  logic       lvl_valid;
  logic       lvl_ready;
  level_set_t lvl_data;
  rgb_t       rgb_next;
  rgb_t       rgb_data;

  assign pix_data.hue        = pix.hue;
  assign pix_data.saturation = pix.saturation;
  assign pix_data.brightness = pix.brightness;

  hsvc_sector_calc u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .in_data   (pix_data),
    .out_valid (fac_valid),
    .out_ready (fac_ready),
    .out_data  (fac_data)
  );

  hsvc_level_scale u_level (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fac_valid),
    .in_ready  (fac_ready),
    .in_data   (fac_data),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_data  (lvl_data)
  );

  assign lvl_ready = !rgb.valid || rgb.ready;

  always_comb begin
    case (lvl_data.sector)
      SECTOR_0: rgb_next = '{lvl_data.brightness, lvl_data.t, lvl_data.p};
      SECTOR_1: rgb_next = '{lvl_data.q, lvl_data.brightness, lvl_data.p};
      SECTOR_2: rgb_next = '{lvl_data.p, lvl_data.brightness, lvl_data.t};
      SECTOR_3: rgb_next = '{lvl_data.p, lvl_data.q, lvl_data.brightness};
      SECTOR_4: rgb_next = '{lvl_data.t, lvl_data.p, lvl_data.brightness};
      default:  rgb_next = '{lvl_data.brightness, lvl_data.p, lvl_data.q};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (lvl_ready) begin
      rgb.valid <= lvl_valid;
    end
    if (lvl_ready && lvl_valid) begin
      rgb_data <= rgb_next;
    end
  end

  assign rgb.red   = rgb_data.red;
  assign rgb.green = rgb_data.green;
  assign rgb.blue  = rgb_data.blue;

  `HSVC_ASSERT_SAME(a_full_only_when_stalled, clk, rst, !pix.ready,
                    rgb.valid && !rgb.ready, "input held off without output stall")
  `HSVC_ASSERT_SAME(a_sector_range, clk, rst, lvl_valid, lvl_data.sector <= SECTOR_5,
                    "sector out of range")
  `HSVC_ASSERT_SAME(a_levels_bounded, clk, rst, lvl_valid,
                    (lvl_data.p <= lvl_data.brightness) &&
                    (lvl_data.q <= lvl_data.brightness) &&
                    (lvl_data.t <= lvl_data.brightness), "level above brightness")
  `HSVC_ASSERT_NEXT(a_result_follows, clk, rst, lvl_valid && lvl_ready, rgb.valid,
                    "result lost at output stage")

endmodule

FILE: src/hsvc_sector_calc.sv
// ----------------------------------------------------------------------------
// HSV converter sector stages
// Two stages: split hue*6 into sector and fraction, then form the three
// scale factors 255-s, 255-(f*s>>16) and 255-((65536-f)*s>>16).
// ----------------------------------------------------------------------------
module hsvc_sector_calc (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvc_pkg::pixel_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvc_pkg::factor_t out_data
);
  import hsvc_pkg::*;

  logic              va;
  logic              rdy_a;
  logic              rdy_b;
  sector_t           sector_a;
  hue_t              frac_a;
  level_t            sat_a;
  level_t            bri_a;
  logic [HUE_W+2:0]  scaled;
  logic [HUE_W:0]    cofrac;
  logic [HUE_W+LEVEL_W-1:0] prod_q;
  logic [HUE_W+LEVEL_W:0]   prod_t;
  factor_t           fac_next;

  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  assign scaled = {1'b0, in_data.hue, 2'b00} + {2'b00, in_data.hue, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid;
    end
    if (rdy_a && in_valid) begin
      sector_a <= scaled[HUE_W+SECT_W-1:HUE_W];
      frac_a   <= scaled[HUE_W-1:0];
      sat_a    <= in_data.saturation;
      bri_a    <= in_data.brightness;
    end
  end

  assign cofrac = {1'b1, {HUE_W{1'b0}}} - {1'b0, frac_a};
  assign prod_q = frac_a * sat_a;
  assign prod_t = cofrac * sat_a;

  always_comb begin
    fac_next.sector     = sector_a;
    fac_next.fp         = LEVEL_MAX - sat_a;
    fac_next.fq         = LEVEL_MAX - prod_q[HUE_W+LEVEL_W-1:HUE_W];
    fac_next.ft         = LEVEL_MAX - prod_t[HUE_W+LEVEL_W-1:HUE_W];
    fac_next.brightness = bri_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_b) begin
      out_valid <= va;
    end
    if (rdy_b && va) begin
      out_data <= fac_next;
    end
  end

endmodule

FILE: src/hsvc_level_scale.sv
// ----------------------------------------------------------------------------
// HSV converter level stages
// Two stages: multiply brightness by each factor, then divide by 255.
// ----------------------------------------------------------------------------
module hsvc_level_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsvc_pkg::factor_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsvc_pkg::level_set_t out_data
);
  import hsvc_pkg::*;

  logic    vc;
  logic    rdy_c;
  logic    rdy_d;
  sector_t sector_c;
  level_t  bri_c;
  prod_t   prod_p;
  prod_t   prod_q;
  prod_t   prod_t_c;

  assign rdy_d    = !out_valid || out_ready;
  assign rdy_c    = !vc || rdy_d;
  assign in_ready = rdy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= in_valid;
    end
    if (rdy_c && in_valid) begin
      sector_c <= in_data.sector;
      bri_c    <= in_data.brightness;
      prod_p   <= in_data.brightness * in_data.fp;
      prod_q   <= in_data.brightness * in_data.fq;
      prod_t_c <= in_data.brightness * in_data.ft;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_d) begin
      out_valid <= vc;
    end
    if (rdy_d && vc) begin
      out_data.sector     <= sector_c;
      out_data.p          <= div255(prod_p);
      out_data.q          <= div255(prod_q);
      out_data.t          <= div255(prod_t_c);
      out_data.brightness <= bri_c;
    end
  end

endmodule
